### sv/cwfr_pkg.sv
`timescale 1ns / 1ps
// Package for the checked word frame receiver: receive phases, result codes,
// the frame event struct and default constants. Depends on nothing.
package cwfr_pkg;

   localparam int WORD_COUNT_DEFAULT = 10;
   localparam logic [7:0] MARKER_RESET = 8'h24;

   // Result codes for the receive state field.
   localparam logic [1:0] RX_IDLE    = 2'd0;
   localparam logic [1:0] RX_COLLECT = 2'd1;
   localparam logic [1:0] RX_CHECK   = 2'd2;
   localparam logic [1:0] RX_ACCEPT  = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_COLLECT = 4'b0010,
      PH_CHECK   = 4'b0100,
      PH_ACCEPT  = 4'b1000
   } phase_type;

   // What one accepted byte did to the frame.
   typedef struct packed {
      logic       accepted;
      logic [1:0] state_code;
   } frame_ev_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_COLLECT: code = RX_COLLECT;
         PH_CHECK:   code = RX_CHECK;
         PH_ACCEPT:  code = RX_ACCEPT;
         default:    code = RX_IDLE;
      endcase
      return code;
   endfunction

endpackage

### sv/checked_word_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Top level of the checked word frame receiver: handshakes, word RAM,
// read-out sequencer and result register. Depends on cwfr_pkg, cwfr_ram
// and cwfr_frame_ctrl.
//
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  req_rx_byte
//  rsp_      out        rsp_valid/rsp_stall  rsp_rx_state, rsp_word_valid,
//                                            rsp_channel, rsp_payload_word,
//                                            rsp_last
//  csr_      in         csr_wr_en            csr_wr_data (start marker)
//
// A byte that does not complete a good frame yields one beat. A byte that
// completes a good frame holds the input while the frame is read out: after
// the RAM's registered read, one word read per cycle, while the result register
// is free, from the word RAM's single read port, each going to the result register.
// Reset is synchronous and active high; it clears the phase, index, sum,
// sequencer and result valid, and sets the start marker to '$'.
// A stall on the result side holds the result register and the read-out, and
// stalls the input only while the result register cannot be freed.
module checked_word_frame_receiver_unit #(
   parameter int WORD_COUNT = cwfr_pkg::WORD_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_rx_state,
   output logic        rsp_word_valid,
   output logic [3:0]  rsp_channel,
   output logic [31:0] rsp_payload_word,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import cwfr_pkg::*;

   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // The sequencer either takes bytes or reads an accepted frame out.
   typedef enum logic [1:0] {
      ST_RUN  = 2'b01,
      ST_EMIT = 2'b10
   } seq_type;

   seq_type      st_ff, st_in;
   logic         rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]   marker_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   rsp_state_ff, rsp_state_in;
   logic         rsp_word_valid_ff, rsp_word_valid_in;
   logic [3:0]   rsp_channel_ff, rsp_channel_in;
   logic [31:0]  rsp_word_ff, rsp_word_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_load;

   logic         out_free;
   logic         in_take;
   frame_ev_type ev;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]  wr_data;
   logic         rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]  rd_data;
   logic         rd_last;

   // The result register can take a new beat when it is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((st_ff == ST_RUN) && out_free);
   assign in_take   = req_valid && !req_stall;

   cwfr_frame_ctrl #(
      .WORD_COUNT(WORD_COUNT)
   ) u_frame_ctrl (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (in_take),
      .rx_byte     (req_rx_byte),
      .start_marker(marker_ff),
      .ev          (ev),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // Payload words are written during collection and read only after the
   // checksum byte, so a write and a read of the same word never overlap.
   cwfr_ram #(
      .WIDTH(32),
      .DEPTH(WORD_COUNT)
   ) u_word_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_last = (rd_idx_ff == AW'(WORD_COUNT - 1));

   always_comb begin
      st_in             = st_ff;
      rd_pend_in        = rd_pend_ff;
      rd_idx_in         = rd_idx_ff;
      rd_en             = 1'b0;
      rd_addr           = rd_idx_ff;
      rsp_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_state_in      = ev.state_code;
      rsp_word_valid_in = 1'b0;
      rsp_channel_in    = '0;
      rsp_word_in       = '0;
      rsp_last_in       = 1'b1;
      case (st_ff)
         ST_RUN: begin
            if (in_take) begin
               if (ev.accepted) begin
                  // Start the read-out with the first word of the frame.
                  st_in      = ST_EMIT;
                  rd_en      = 1'b1;
                  rd_addr    = '0;
                  rd_idx_in  = '0;
                  rd_pend_in = 1'b1;
               end else begin
                  rsp_load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rd_pend_ff && out_free) begin
               rsp_load          = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_state_in      = RX_ACCEPT;
               rsp_word_valid_in = 1'b1;
               rsp_channel_in    = 4'(rd_idx_ff);
               rsp_word_in       = rd_data;
               rsp_last_in       = rd_last;
               if (rd_last) begin
                  rd_pend_in = 1'b0;
                  st_in      = ST_RUN;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff + AW'(1);
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
         end
         default: begin
            st_in      = ST_RUN;
            rd_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_RUN;
         rd_pend_ff   <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         marker_ff    <= MARKER_RESET;
      end else begin
         st_ff        <= st_in;
         rd_pend_ff   <= rd_pend_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
      end
   end

   // The result payload needs no reset; it is qualified by the valid bit.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_state_ff      <= rsp_state_in;
         rsp_word_valid_ff <= rsp_word_valid_in;
         rsp_channel_ff    <= rsp_channel_in;
         rsp_word_ff       <= rsp_word_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rx_state     = rsp_state_ff;
   assign rsp_word_valid   = rsp_word_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_payload_word = rsp_word_ff;
   assign rsp_last         = rsp_last_ff;

   // No byte is taken while an accepted frame is being read out.
   a_no_take_in_emit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EMIT) |-> req_stall)
      else $error("byte accepted during frame read-out");

   // A read is outstanding exactly while the frame is being read out.
   a_pend_in_emit: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff == (st_ff == ST_EMIT))
      else $error("read-out sequencer and pending read disagree");

   // A word beat that is not the last keeps the sequencer reading.
   a_word_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_valid_ff && !rsp_last_ff) |-> (st_ff == ST_EMIT))
      else $error("read-out ended before the last word");

   // The last word beat hands control back to byte reception.
   a_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_EMIT) && rd_pend_ff && out_free && rd_last) |=> (st_ff == ST_RUN))
      else $error("read-out did not end after the last word");

endmodule

### sv/cwfr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cwfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cwfr_frame_ctrl.sv
`timescale 1ns / 1ps
// Frame tracking for the receiver: phase, write index, running sum and the
// assembly of payload words for the word RAM. Depends on cwfr_pkg.
module cwfr_frame_ctrl #(
   parameter int WORD_COUNT = cwfr_pkg::WORD_COUNT_DEFAULT,
   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_take,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             start_marker,
   output cwfr_pkg::frame_ev_type ev,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [31:0]            wr_data
);
   import cwfr_pkg::*;

   localparam int STORE_BYTES = 4 * WORD_COUNT;
   localparam int IW = $clog2(STORE_BYTES + 1);

   phase_type     phase_ff, phase_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]    sum_ff, sum_in;
   logic [23:0]   acc_ff, acc_in;
   logic          full;
   logic          accepted;

   assign full = (idx_ff == IW'(STORE_BYTES));

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      accepted = 1'b0;
      wr_en    = 1'b0;
      case (phase_ff)
         PH_IDLE, PH_ACCEPT: begin
            if (rx_byte == start_marker) begin
               phase_in = PH_COLLECT;
               idx_in   = '0;
            end
         end
         PH_COLLECT: begin
            if (!full) begin
               idx_in = idx_ff + IW'(1);
               case (idx_ff[1:0])
                  2'd0:    acc_in[7:0]   = rx_byte;
                  2'd1:    acc_in[15:8]  = rx_byte;
                  2'd2:    acc_in[23:16] = rx_byte;
                  default: wr_en         = byte_take;
               endcase
            end else begin
               phase_in = PH_CHECK;
            end
            sum_in = sum_ff + rx_byte;
         end
         PH_CHECK: begin
            if (8'(sum_ff + start_marker) == rx_byte) begin
               phase_in = PH_ACCEPT;
               accepted = 1'b1;
            end else begin
               phase_in = PH_IDLE;
            end
            sum_in = '0;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign ev.accepted   = accepted;
   assign ev.state_code = phase_code(phase_in);
   assign wr_addr       = AW'(idx_ff[IW-1:2]);
   assign wr_data       = {rx_byte, acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         sum_ff   <= '0;
      end else if (byte_take) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take) begin
         acc_ff <= acc_in;
      end
   end

endmodule

### verif/cwfr_frame_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the checked word frame receiver: a frame predictor and a queue of expected
// result beats. Depends on cwfr_pkg for the receive state codes and the marker reset value.
package cwfr_tb_pkg;

   import cwfr_pkg::*;

   localparam int WORDS       = cwfr_pkg::WORD_COUNT_DEFAULT;
   localparam int STORE_BYTES = 4 * WORDS;

   typedef struct packed {
      logic [1:0]  rx_state;
      logic        word_valid;
      logic [3:0]  channel;
      logic [31:0] word;
      logic        last;
   } beat_type;

   class frame_scoreboard;
      logic [7:0]  marker;
      logic [1:0]  phase;
      logic [7:0]  store [STORE_BYTES];
      int unsigned wr_index;
      logic [7:0]  sum;
      beat_type    awaited_beats [$];
      int unsigned errors;
      int unsigned beats_seen;
      int unsigned bytes_seen;
      int unsigned frames_good;
      int unsigned frames_bad;

      function new();
         marker      = MARKER_RESET;
         phase       = RX_IDLE;
         wr_index    = 0;
         sum         = '0;
         errors      = 0;
         beats_seen  = 0;
         bytes_seen  = 0;
         frames_good = 0;
         frames_bad  = 0;
      endfunction

      function void set_marker(input logic [7:0] value);
         marker = value;
      endfunction

      function int outstanding();
         return awaited_beats.size();
      endfunction

      // Advance the frame state by one accepted byte and queue the beats it causes.
      function void note_byte(input logic [7:0] b);
         beat_type   nb;
         logic       hit;
         logic [7:0] total;
         hit = 1'b0;
         bytes_seen++;
         case (phase)
            RX_COLLECT: begin
               if (wr_index < STORE_BYTES) begin
                  store[wr_index] = b;
                  wr_index++;
               end else begin
                  phase = RX_CHECK;
               end
               sum = sum + b;
            end
            RX_CHECK: begin
               total = sum + marker;
               if (total == b) begin
                  phase = RX_ACCEPT;
                  hit   = 1'b1;
                  frames_good++;
               end else begin
                  phase = RX_IDLE;
                  frames_bad++;
               end
               sum = '0;
            end
            default: begin
               if (b == marker) begin
                  phase    = RX_COLLECT;
                  wr_index = 0;
               end
            end
         endcase
         if (!hit) begin
            nb.rx_state   = phase;
            nb.word_valid = 1'b0;
            nb.channel    = '0;
            nb.word       = '0;
            nb.last       = 1'b1;
            awaited_beats.push_back(nb);
         end else begin
            for (int k = 0; k < WORDS; k++) begin
               nb.rx_state   = phase;
               nb.word_valid = 1'b1;
               nb.channel    = 4'(k);
               nb.word       = {store[4*k+3], store[4*k+2], store[4*k+1], store[4*k]};
               nb.last       = (k == WORDS - 1);
               awaited_beats.push_back(nb);
            end
         end
      endfunction

      function void check_beat(input beat_type got);
         beat_type want;
         beats_seen++;
         if (awaited_beats.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: state %0d valid %0d chan %0d word %h last %0d",
                        got.rx_state, got.word_valid, got.channel, got.word, got.last);
            return;
         end
         want = awaited_beats.pop_front();
         if (got.rx_state !== want.rx_state || got.word_valid !== want.word_valid ||
             got.channel !== want.channel || got.word !== want.word ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("beat mismatch: expected state %0d valid %0d chan %0d word %h last %0d, got state %0d valid %0d chan %0d word %h last %0d",
                        want.rx_state, want.word_valid, want.channel, want.word, want.last,
                        got.rx_state, got.word_valid, got.channel, got.word, got.last);
         end
      endfunction

      function void close_out();
         if (awaited_beats.size() != 0) begin
            errors += awaited_beats.size();
            $display("%0d expected beats never arrived", awaited_beats.size());
         end
      endfunction
   endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench for checked_word_frame_receiver_unit: drives framed byte streams under
// several start markers and checks every result beat. Depends on cwfr_pkg and cwfr_tb_pkg.
module testbench;

   import cwfr_tb_pkg::*;

   // Consecutive cycles with no beat on either channel before the run is abandoned.
   localparam int IDLE_LIMIT = 4000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_rx_state;
   logic        rsp_word_valid;
   logic [3:0]  rsp_channel;
   logic [31:0] rsp_payload_word;
   logic        rsp_last;

   frame_scoreboard sb;
   beat_type        got;
   logic [7:0]      frame_bytes [$];
   int              burst_left  = 0;
   int              idle_cycles = 0;
   int              stall_mode  = 0;
   int              stall_left  = 0;
   int              stall_tick  = 0;
   int              settings_used = 1;

   checked_word_frame_receiver_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rx_state     (rsp_rx_state),
      .rsp_word_valid   (rsp_word_valid),
      .rsp_channel      (rsp_channel),
      .rsp_payload_word (rsp_payload_word),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #2 clock = ~clock;

   // The receiver stalls on a pattern of its own: it switches between no stalling, light
   // random stalling, a fixed one-in-four rhythm and heavy random stalling, each for a
   // stretch of random length. Driven at the rising edge, so it is settled by the falling one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            2:       rsp_stall <= (stall_tick % 4 == 0);
            3:       rsp_stall <= ($urandom_range(0, 2) != 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Everything the testbench drives changes only at rising edges, so the values seen at the
   // falling edge are exactly those the block will act on at the next rising edge. Result
   // beats are checked here, and the watchdog counts cycles in which no beat moves at all.
   always @(negedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.rx_state   = rsp_rx_state;
            got.word_valid = rsp_word_valid;
            got.channel    = rsp_channel;
            got.word       = rsp_payload_word;
            got.last       = rsp_last;
            sb.check_beat(got);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Present one byte and hold it until the block takes it. The sender works in bursts of
   // random length; between bursts it may drop valid for a random gap. The occasional very long
   // burst gives stretches with no idling on the input side. Valid is only lowered when a gap
   // really follows, so it never gets two assignments in one time step.
   task automatic send_byte(input logic [7:0] b);
      int  gap;
      logic took;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         took = !req_stall;
         if (took)
            sb.note_byte(b);
         @(posedge clock);
      end while (!took);
   endtask

   // Stop sending and wait until every expected beat has come back, then allow the block's
   // read-out latency to pass so that it is fully quiet before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (WORDS + 4) @(posedge clock);
   endtask

   task automatic write_marker(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_marker(value);
      settings_used++;
   endtask

   // Build a whole frame into frame_bytes: the opening marker, the payload, the extra byte and
   // the checksum byte. The checksum uses check_mk, which may differ from the opening marker
   // when the register is to be rewritten in the middle of the frame. Fill styles: 0 random,
   // 1 all zero, 2 all ones, 3 random with many copies of the marker among the data.
   task automatic build_frame(input logic [7:0] open_mk, input logic [7:0] check_mk,
                              input bit good, input int fill);
      logic [7:0] sum;
      logic [7:0] b;
      frame_bytes.delete();
      frame_bytes.push_back(open_mk);
      sum = '0;
      for (int i = 0; i <= STORE_BYTES; i++) begin
         case (fill)
            1:       b = 8'h00;
            2:       b = 8'hFF;
            3:       b = ($urandom_range(0, 2) == 0) ? open_mk : 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(0, 255));
         endcase
         // The byte after the store is full is always random, so it varies even in flat fills.
         if (i == STORE_BYTES)
            b = 8'($urandom_range(0, 255));
         frame_bytes.push_back(b);
         sum = sum + b;
      end
      sum = sum + check_mk;
      if (!good)
         sum = sum ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(sum);
   endtask

   task automatic send_span(input int lo, input int hi);
      for (int i = lo; i < hi; i++)
         send_byte(frame_bytes[i]);
   endtask

   // Bytes other than the marker, sent while no frame is open, which the block ignores.
   task automatic send_noise(input int count, input logic [7:0] mk);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         do b = 8'($urandom_range(0, 255)); while (b == mk);
         send_byte(b);
      end
   endtask

   initial begin
      logic [7:0] mk;
      int         counted;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening, under the marker's reset value: ignored bytes at the extremes and
      // either side of the marker, while the block is idle.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h23);
      send_byte(8'h25);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h01);
      send_byte(8'h80);

      // A good frame opened with the reset marker, with many copies of that marker among the
      // data, whose checksum is built for a new marker written while the frame is half
      // collected. The block must use the marker that holds when the checksum byte arrives.
      // Bytes after acceptance are then ignored.
      build_frame(cwfr_pkg::MARKER_RESET, 8'h5A, 1'b1, 3);
      send_span(0, 21);
      drain();
      write_marker(8'h5A);
      send_span(21, frame_bytes.size());
      send_noise(3, 8'h5A);

      // Random part: one setting per phase, at both extremes of the marker. The first phase
      // runs a good frame with a randomly chosen fill, the second a frame with a bad checksum, at
      // times with ignored noise before them. The sender pauses until every beat has come back before
      // each register write.
      for (int p = 0; p < 2; p++) begin
         mk = (p == 0) ? 8'h00 : 8'hFF;
         drain();
         write_marker(mk);
         counted = 0;
         while (counted < 40) begin
            if ($urandom_range(0, 2) == 0)
               send_noise($urandom_range(1, 4), mk);
            case (p)
               1:       build_frame(mk, mk, 1'b0, $urandom_range(0, 3));
               default: build_frame(mk, mk, 1'b1, $urandom_range(0, 2));
            endcase
            send_span(0, frame_bytes.size());
            counted += frame_bytes.size();
         end
      end

      // Let the last beats come home, then keep watching the block to show that
      // nothing unexpected follows.
      drain();
      sb.close_out();

      $display("summary: %0d bytes under %0d marker settings, %0d frames accepted, %0d rejected",
               sb.bytes_seen, settings_used, sb.frames_good, sb.frames_bad);
      $display("summary: %0d result beats checked, %0d failures", sb.beats_seen, sb.errors);
      if (sb.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
